>>> sv/qpr_pkg.sv
// qpr_pkg: shared constants, types and the cordic arctangent table
// for the quaternion point rotator; no dependencies
package qpr_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_W   = 16;  // width of every configuration register
    localparam int Q_W     = 18;  // quaternion components, Q3.15
    localparam int QP_W    = 2 * Q_W;
    localparam int MAT_W   = 38;  // rotation matrix entries, Q30
    localparam int ANG_W   = 28;  // cordic angle, Q24 radians
    localparam int CXY_W   = 33;  // cordic x and y, Q30
    localparam int AXP_W   = CFG_W + CXY_W;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_AXIS_X = 2'd0;
    localparam logic [1:0] CFG_AXIS_Y = 2'd1;
    localparam logic [1:0] CFG_AXIS_Z = 2'd2;
    localparam logic [1:0] CFG_ANGLE  = 2'd3;

    localparam logic [CFG_W-1:0] AXIS_X_RST = 16'd0;
    localparam logic [CFG_W-1:0] AXIS_Y_RST = 16'd0;
    localparam logic [CFG_W-1:0] AXIS_Z_RST = 16'd16384;
    localparam logic [CFG_W-1:0] ANGLE_RST  = 16'd0;

    localparam logic signed [CXY_W-1:0] CORDIC_K    = 33'sd652032874;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;

    localparam logic signed [Q_W-1:0] Q_MAX = 18'sd131071;
    localparam logic signed [Q_W-1:0] Q_MIN = -18'sd131072;

    // identity entry: one in Q30
    localparam logic [MAT_W-1:0] MAT_ONE = 38'd1073741824;

    // row-major 3x3 matrix, entries signed Q30
    typedef logic [8:0][MAT_W-1:0] t_matrix;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            5'd24:   v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/quaternion_point_rotator.sv
// quaternion_point_rotator: top level; rotates a stream of points by the
// configured axis and angle; depends on qpr_pkg, qpr_quat_gen, qpr_rot_pipe
//
// usage
//   configuration: i_cfg_we with i_cfg_idx (0 axis_x, 1 axis_y, 2 axis_z,
//   3 rot_angle) and i_cfg_data; each write re-derives the quaternion and
//   its rotation matrix with an iterative cordic, one step a cycle;
//   s_axis_tready stays low meanwhile
//   input stream: one point word per handshake, x, y, z from the low bits
//   output stream: the rotated point in tdata, the clip flag in tuser
//   throughput: one word per cycle while the receiver is ready and no
//   matrix rebuild is under way, set by the four-stage multiply, sum,
//   round and saturate pipeline; a word passes those stages in order
//   before m_axis_tvalid rises
//   reset: clears registers to axis (0,0,1) and angle zero, loads the exact
//   identity rotation and empties the pipeline
//   receiver stall: valid bits collapse bubbles, then the whole pipeline
//   holds; no word is dropped or repeated
module quaternion_point_rotator #(
    parameter int COORD_WIDTH  = qpr_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = qpr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [qpr_pkg::CFG_W-1:0]       i_cfg_data,
    // input points
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // rotated points
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // rotated_x, rotated_y, rotated_z, zero fill
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic                            m_axis_tuser
);

    localparam int DATA_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                   cfg_busy;
    qpr_pkg::t_matrix       matrix;
    logic                   pipe_ready;
    logic [COORD_WIDTH-1:0] rx, ry, rz;
    logic                   sat;

    qpr_quat_gen #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_quat_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (cfg_busy),
        .o_matrix   (matrix)
    );

    // hold off points while the matrix is being rebuilt
    qpr_rot_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rot_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_matrix (matrix),
        .i_valid  (s_axis_tvalid && !cfg_busy),
        .o_ready  (pipe_ready),
        .i_px     (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_py     (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_pz     (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_rx     (rx),
        .o_ry     (ry),
        .o_rz     (rz),
        .o_sat    (sat)
    );

    assign s_axis_tready = pipe_ready && !cfg_busy;
    assign m_axis_tdata  = DATA_W'({rz, ry, rx});
    assign m_axis_tuser  = sat;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !cfg_busy)
        else $error("point accepted during matrix rebuild");
    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> rx == C_MAX || rx == C_MIN
            || ry == C_MAX || ry == C_MIN || rz == C_MAX || rz == C_MIN)
        else $error("clip flag without a clipped coordinate");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

>>> sv/qpr_quat_gen.sv
// qpr_quat_gen: configuration registers and the sequencer that derives the
// quaternion and its rotation matrix; depends on qpr_pkg
module qpr_quat_gen #(
    parameter int CORDIC_STEPS = qpr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [qpr_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_busy,
    output qpr_pkg::t_matrix                o_matrix
);

    localparam int N_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CNT_W   = $clog2(N_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(N_STEPS - 1);

    // identity rotation, ones on the diagonal
    localparam qpr_pkg::t_matrix MAT_RST = {qpr_pkg::MAT_ONE, {(3*qpr_pkg::MAT_W){1'b0}},
        qpr_pkg::MAT_ONE, {(3*qpr_pkg::MAT_W){1'b0}}, qpr_pkg::MAT_ONE};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_AXM  = 3'd2;
    localparam logic [2:0] S_QNT  = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_MAT  = 3'd5;

    logic [2:0]                             r_state, n_state;
    logic [CNT_W-1:0]                       r_cnt;
    logic signed [qpr_pkg::CFG_W-1:0]       r_ax, r_ay, r_az, r_ang;
    logic signed [qpr_pkg::CFG_W-1:0]       n_ang;
    logic signed [qpr_pkg::ANG_W-1:0]       r_z, z0;
    logic signed [qpr_pkg::CXY_W-1:0]       r_x, r_y, r_xs;
    logic signed [qpr_pkg::CXY_W-1:0]       xsh, ysh, xf, yf;
    logic signed [qpr_pkg::ANG_W-1:0]       at;
    logic                                   r_flip;
    logic signed [qpr_pkg::AXP_W-1:0]       r_pa, r_pb, r_pc;
    logic signed [qpr_pkg::Q_W-1:0]         r_w, r_a, r_b, r_c;
    logic signed [qpr_pkg::QP_W-1:0]        r_ww, r_aa, r_bb, r_cc, r_ab, r_ac, r_bc;
    logic signed [qpr_pkg::QP_W-1:0]        r_wa, r_wb, r_wc;
    logic signed [qpr_pkg::MAT_W-1:0]       ww, aa, bb, cc, ab, ac, bc, wa, wb, wc;
    qpr_pkg::t_matrix                       r_mat;

    function automatic logic signed [qpr_pkg::Q_W-1:0] sat_q(
        input logic signed [qpr_pkg::AXP_W:0] v);
        logic signed [qpr_pkg::Q_W-1:0] o;
        if (v > (qpr_pkg::AXP_W + 1)'(qpr_pkg::Q_MAX))       o = qpr_pkg::Q_MAX;
        else if (v < (qpr_pkg::AXP_W + 1)'(qpr_pkg::Q_MIN))  o = qpr_pkg::Q_MIN;
        else                                                 o = v[qpr_pkg::Q_W-1:0];
        return o;
    endfunction

    assign n_ang = (i_cfg_we && i_cfg_idx == qpr_pkg::CFG_ANGLE) ? i_cfg_data : r_ang;
    assign z0    = qpr_pkg::ANG_W'(n_ang) <<< 11;
    assign xsh   = r_x >>> r_cnt;
    assign ysh   = r_y >>> r_cnt;
    assign at    = qpr_pkg::atan_q24(5'(r_cnt));
    assign xf    = r_flip ? -r_x : r_x;
    assign yf    = r_flip ? -r_y : r_y;

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = S_ROT;
        end else begin
            unique case (r_state)
                S_IDLE:  n_state = S_IDLE;
                S_ROT:   n_state = (r_cnt == LAST_STEP) ? S_AXM : S_ROT;
                S_AXM:   n_state = S_QNT;
                S_QNT:   n_state = S_PRD;
                S_PRD:   n_state = S_MAT;
                S_MAT:   n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= qpr_pkg::AXIS_X_RST;
            r_ay    <= qpr_pkg::AXIS_Y_RST;
            r_az    <= qpr_pkg::AXIS_Z_RST;
            r_ang   <= qpr_pkg::ANGLE_RST;
            r_mat   <= MAT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    qpr_pkg::CFG_AXIS_X: r_ax  <= i_cfg_data;
                    qpr_pkg::CFG_AXIS_Y: r_ay  <= i_cfg_data;
                    qpr_pkg::CFG_AXIS_Z: r_az  <= i_cfg_data;
                    qpr_pkg::CFG_ANGLE:  r_ang <= i_cfg_data;
                    default:             r_ang <= r_ang;
                endcase
            end
            if (!i_cfg_we && r_state == S_MAT) begin
                r_mat[0] <= ww + aa - bb - cc;
                r_mat[1] <= (ab - wc) <<< 1;
                r_mat[2] <= (ac + wb) <<< 1;
                r_mat[3] <= (ab + wc) <<< 1;
                r_mat[4] <= ww - aa + bb - cc;
                r_mat[5] <= (bc - wa) <<< 1;
                r_mat[6] <= (ac - wb) <<< 1;
                r_mat[7] <= (bc + wa) <<< 1;
                r_mat[8] <= ww - aa - bb + cc;
            end
        end
    end

    // cordic and product datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_cnt <= '0;
            r_x   <= qpr_pkg::CORDIC_K;
            r_y   <= '0;
            // fold the half angle into [-pi/2, pi/2]
            if (z0 > qpr_pkg::HALF_PI_Q24) begin
                r_z    <= z0 - qpr_pkg::PI_Q24;
                r_flip <= 1'b1;
            end else if (z0 < -qpr_pkg::HALF_PI_Q24) begin
                r_z    <= z0 + qpr_pkg::PI_Q24;
                r_flip <= 1'b1;
            end else begin
                r_z    <= z0;
                r_flip <= 1'b0;
            end
        end else if (r_state == S_ROT) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_z >= 0) begin
                r_x <= r_x - ysh;
                r_y <= r_y + xsh;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ysh;
                r_y <= r_y - xsh;
                r_z <= r_z + at;
            end
        end
        if (r_state == S_AXM) begin
            r_xs <= xf;
            r_pa <= r_ax * yf;
            r_pb <= r_ay * yf;
            r_pc <= r_az * yf;
        end
        if (r_state == S_QNT) begin
            r_w <= sat_q(((qpr_pkg::AXP_W + 1)'(r_xs) + (1 <<< 14)) >>> 15);
            r_a <= sat_q(((qpr_pkg::AXP_W + 1)'(r_pa) + (1 <<< 28)) >>> 29);
            r_b <= sat_q(((qpr_pkg::AXP_W + 1)'(r_pb) + (1 <<< 28)) >>> 29);
            r_c <= sat_q(((qpr_pkg::AXP_W + 1)'(r_pc) + (1 <<< 28)) >>> 29);
        end
        if (r_state == S_PRD) begin
            r_ww <= r_w * r_w;
            r_aa <= r_a * r_a;
            r_bb <= r_b * r_b;
            r_cc <= r_c * r_c;
            r_ab <= r_a * r_b;
            r_ac <= r_a * r_c;
            r_bc <= r_b * r_c;
            r_wa <= r_w * r_a;
            r_wb <= r_w * r_b;
            r_wc <= r_w * r_c;
        end
    end

    assign ww = qpr_pkg::MAT_W'(r_ww);
    assign aa = qpr_pkg::MAT_W'(r_aa);
    assign bb = qpr_pkg::MAT_W'(r_bb);
    assign cc = qpr_pkg::MAT_W'(r_cc);
    assign ab = qpr_pkg::MAT_W'(r_ab);
    assign ac = qpr_pkg::MAT_W'(r_ac);
    assign bc = qpr_pkg::MAT_W'(r_bc);
    assign wa = qpr_pkg::MAT_W'(r_wa);
    assign wb = qpr_pkg::MAT_W'(r_wb);
    assign wc = qpr_pkg::MAT_W'(r_wc);

    assign o_busy   = (r_state != S_IDLE);
    assign o_matrix = r_mat;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROT |-> r_cnt <= LAST_STEP)
        else $error("cordic step count past last step");
    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_state == S_ROT && r_cnt == '0)
        else $error("config write did not restart derivation");
    a_mat_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_state) != S_MAT |-> $stable(r_mat))
        else $error("matrix changed outside final step");

endmodule

>>> sv/qpr_rot_pipe.sv
// qpr_rot_pipe: four-stage matrix times point pipeline with rounding and
// saturation; depends on qpr_pkg
module qpr_rot_pipe #(
    parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qpr_pkg::t_matrix                i_matrix,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [COORD_WIDTH-1:0]          i_px,
    input  logic [COORD_WIDTH-1:0]          i_py,
    input  logic [COORD_WIDTH-1:0]          i_pz,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [COORD_WIDTH-1:0]          o_rx,
    output logic [COORD_WIDTH-1:0]          o_ry,
    output logic [COORD_WIDTH-1:0]          o_rz,
    output logic                            o_sat
);

    localparam int LO_W = COORD_WIDTH / 2;
    localparam int HI_W = COORD_WIDTH - LO_W;
    localparam int PL_W = qpr_pkg::MAT_W + LO_W + 1;
    localparam int PH_W = qpr_pkg::MAT_W + HI_W;
    localparam int SW   = qpr_pkg::MAT_W + COORD_WIDTH + 3;
    localparam int RW   = SW - 30;
    localparam logic signed [RW-1:0] R_MAX = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);

    logic [COORD_WIDTH-1:0]             p [3];
    logic signed [LO_W:0]               lo [3];
    logic signed [HI_W-1:0]             hi [3];
    logic signed [qpr_pkg::MAT_W-1:0]   m [9];

    logic                               r_v1, r_v2, r_v3, r_v4;
    logic                               rdy1, rdy2, rdy3, rdy4;
    logic signed [PL_W-1:0]             r_pl [9];
    logic signed [PH_W-1:0]             r_ph [9];
    logic signed [PL_W+1:0]             r_sl [3];
    logic signed [PH_W+1:0]             r_sh [3];
    logic signed [RW-1:0]               r_r [3];
    logic signed [SW-1:0]               tot [3];
    logic [COORD_WIDTH-1:0]             sv [3];
    logic [2:0]                         clip;
    logic [COORD_WIDTH-1:0]             r_ox, r_oy, r_oz;
    logic                               r_osat;

    assign p[0] = i_px;
    assign p[1] = i_py;
    assign p[2] = i_pz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo[k] = $signed({1'b0, p[k][LO_W-1:0]});
            hi[k] = $signed(p[k][COORD_WIDTH-1:LO_W]);
        end
        for (int e = 0; e < 9; e++) begin
            m[e] = $signed(i_matrix[e]);
        end
        for (int j = 0; j < 3; j++) begin
            tot[j] = (SW'(r_sh[j]) <<< LO_W) + SW'(r_sl[j]) + (SW'(1) <<< 29);
            if (r_r[j] > R_MAX) begin
                sv[j]   = R_MAX[COORD_WIDTH-1:0];
                clip[j] = 1'b1;
            end else if (r_r[j] < R_MIN) begin
                sv[j]   = R_MIN[COORD_WIDTH-1:0];
                clip[j] = 1'b1;
            end else begin
                sv[j]   = r_r[j][COORD_WIDTH-1:0];
                clip[j] = 1'b0;
            end
        end
    end

    // each stage moves when it is empty or the next one moves
    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int e = 0; e < 9; e++) begin
                r_pl[e] <= m[e] * lo[e % 3];
                r_ph[e] <= m[e] * hi[e % 3];
            end
        end
        if (rdy2) begin
            for (int j = 0; j < 3; j++) begin
                r_sl[j] <= (PL_W+2)'(r_pl[3*j]) + (PL_W+2)'(r_pl[3*j+1])
                         + (PL_W+2)'(r_pl[3*j+2]);
                r_sh[j] <= (PH_W+2)'(r_ph[3*j]) + (PH_W+2)'(r_ph[3*j+1])
                         + (PH_W+2)'(r_ph[3*j+2]);
            end
        end
        if (rdy3) begin
            for (int j = 0; j < 3; j++) begin
                r_r[j] <= RW'(tot[j] >>> 30);
            end
        end
        if (rdy4) begin
            r_ox   <= sv[0];
            r_oy   <= sv[1];
            r_oz   <= sv[2];
            r_osat <= |clip;
        end
    end

    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_rx    = r_ox;
    assign o_ry    = r_oy;
    assign o_rz    = r_oz;
    assign o_sat   = r_osat;

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && !i_ready |-> !o_ready)
        else $error("pipeline full but input ready");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && rdy4 |=> r_v4)
        else $error("word lost between last two stages");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3 && !r_v4)
        else $error("pipeline not empty after reset");

endmodule

>>> tb/quaternion_point_rotator_tb.sv
// quaternion_point_rotator_tb: self-checking stream test of the point rotator;
// a clocked driver and monitor around DUT with a cycle-free rotation predictor
// depends on qpr_pkg and quaternion_point_rotator
module quaternion_point_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam int DW = ((3 * CW + 7) / 8) * 8;
    localparam int STEPS = 16;
    localparam int SETTLE = STEPS + 5 + 10;  // cordic derivation plus margin

    typedef logic [2:0][CW-1:0] t_coord3;    // index 0 is x
    typedef struct {
        t_coord3 pos;
        logic    clip;
    } t_rotated;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [1:0]      i_cfg_idx = '0;
    logic [qpr_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [DW-1:0]   s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [DW-1:0]   m_axis_tdata;
    logic            m_axis_tuser;

    quaternion_point_rotator #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("%0t timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

    // predictor state: register shadows and the derived quaternion, Q3.15
    logic [qpr_pkg::CFG_W-1:0] reg_file [4];
    longint quat_w;
    longint quat_v [3];

    t_coord3  pending_points [$];
    t_rotated expected_rotations [$];
    int       mismatch_count = 0;
    bit       burst_mode = 0;  // no idling on either side while set

    function automatic longint sat18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // half angle folded into +-pi/2, rotation-mode cordic, then axis scaling
    function automatic void derive_quaternion();
        longint z, x, y, t;
        bit flip;
        z = longint'($signed(reg_file[qpr_pkg::CFG_ANGLE])) * 2048;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 26353589) begin
            z -= 52707179;
            flip = 1;
        end else if (z < -26353589) begin
            z += 52707179;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(qpr_pkg::atan_q24(5'(i)));
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(qpr_pkg::atan_q24(5'(i)));
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        quat_w = sat18(round_shift(x, 15));
        for (int k = 0; k < 3; k++)
            quat_v[k] = sat18(round_shift(longint'($signed(reg_file[k])) * y, 29));
    endfunction

    // q*(0,p)*conj(q) as the exact matrix product, rounded once and clipped
    function automatic t_rotated rotate_point(t_coord3 pt);
        longint w, a, b, c, p, acc_hi, acc_lo, r;
        longint m [3][3];
        longint hi [3];
        longint lo [3];
        t_rotated res;
        w = quat_w; a = quat_v[0]; b = quat_v[1]; c = quat_v[2];
        m[0][0] = w*w + a*a - b*b - c*c;
        m[0][1] = 2 * (a*b - w*c);
        m[0][2] = 2 * (a*c + w*b);
        m[1][0] = 2 * (a*b + w*c);
        m[1][1] = w*w - a*a + b*b - c*c;
        m[1][2] = 2 * (b*c - w*a);
        m[2][0] = 2 * (a*c - w*b);
        m[2][1] = 2 * (b*c + w*a);
        m[2][2] = w*w - a*a - b*b + c*c;
        for (int k = 0; k < 3; k++) begin
            p = longint'($signed(pt[k]));
            lo[k] = p & 64'hFFFFFF;
            hi[k] = p >>> 24;
        end
        res.clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            acc_hi = 0;
            acc_lo = 64'sd1 <<< 29;
            for (int k = 0; k < 3; k++) begin
                acc_hi += m[j][k] * hi[k];
                acc_lo += m[j][k] * lo[k];
            end
            r = (acc_hi + (acc_lo >>> 24)) >>> 6;
            if (r > (64'sd1 <<< (CW - 1)) - 1) begin
                r = (64'sd1 <<< (CW - 1)) - 1;
                res.clip = 1'b1;
            end else if (r < -(64'sd1 <<< (CW - 1))) begin
                r = -(64'sd1 <<< (CW - 1));
                res.clip = 1'b1;
            end
            res.pos[j] = r[CW-1:0];
        end
        return res;
    endfunction

    // driver: one point word at a time, random gap after each accepted word unless burst_mode is set
    t_coord3 held_point;
    bit      word_held = 0;
    int      send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rotations.insert(expected_rotations.size(),
                                          rotate_point(held_point));
                word_held = 0;
            end
            if (!word_held) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    held_point = pending_points.pop_front();
                    s_axis_tdata <= DW'(held_point);
                    s_axis_tvalid <= 1'b1;
                    word_held = 1;
                    send_gap = burst_mode ? 0 : $urandom_range(0, 4);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted word with the oldest expectation
    int recv_stall = 0;
    always @(posedge i_clk) begin
        t_rotated want;
        t_coord3 got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[3*CW-1:0];
                if (expected_rotations.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %h/%b",
                             $time, got, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_rotations.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (got[k] !== want.pos[k]) begin
                            $display("%0t coord %0d: expected %h, actual %h",
                                     $time, k, want.pos[k], got[k]);
                            mismatch_count++;
                        end
                    if (m_axis_tuser !== want.clip) begin
                        $display("%0t clip flag: expected %b, actual %b",
                                 $time, want.clip, m_axis_tuser);
                        mismatch_count++;
                    end
                end
                recv_stall = burst_mode ? 0 : $urandom_range(0, 4);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_points.size() > 0 || expected_rotations.size() > 0 || word_held)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write while idle, then let the cordic finish
    task automatic write_reg(logic [1:0] idx, logic [qpr_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_file[idx] = val;
        derive_quaternion();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_all(logic [qpr_pkg::CFG_W-1:0] ax, logic [qpr_pkg::CFG_W-1:0] ay,
                             logic [qpr_pkg::CFG_W-1:0] az, logic [qpr_pkg::CFG_W-1:0] ang);
        write_reg(qpr_pkg::CFG_AXIS_X, ax);
        write_reg(qpr_pkg::CFG_AXIS_Y, ay);
        write_reg(qpr_pkg::CFG_AXIS_Z, az);
        write_reg(qpr_pkg::CFG_ANGLE, ang);
    endtask

    task automatic push_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        t_coord3 pt;
        pt[0] = x; pt[1] = y; pt[2] = z;
        pending_points.insert(pending_points.size(), pt);
    endtask

    // mostly moderate coordinates, some full range so clipping shows up
    task automatic push_random_points(int count);
        t_coord3 pt;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 3) == 0)
                    pt[k] = CW'($urandom);
                else
                    pt[k] = CW'($signed(20'($urandom)));
            pending_points.insert(pending_points.size(), pt);
        end
    endtask

    localparam logic [CW-1:0] PMAX = 24'h7FFFFF;
    localparam logic [CW-1:0] PMIN = 24'h800000;
    localparam logic [CW-1:0] ONE  = 24'h010000;

    initial begin
        logic [qpr_pkg::CFG_W-1:0] ax, ay, az;
        reg_file[qpr_pkg::CFG_AXIS_X] = qpr_pkg::AXIS_X_RST;
        reg_file[qpr_pkg::CFG_AXIS_Y] = qpr_pkg::AXIS_Y_RST;
        reg_file[qpr_pkg::CFG_AXIS_Z] = qpr_pkg::AXIS_Z_RST;
        reg_file[qpr_pkg::CFG_ANGLE]  = qpr_pkg::ANGLE_RST;
        quat_w = 32768;  // reset loads the exact identity
        for (int k = 0; k < 3; k++) quat_v[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // identity after reset: coordinate extremes pass through
        push_point(PMAX, PMAX, PMAX);
        push_point(PMIN, PMIN, PMIN);
        push_point('0, '0, '0);
        push_point('1, ONE, PMIN);
        push_point(PMAX, PMIN, '0);
        wait_drained();

        // quarter turn about z, written as a partial update
        write_reg(qpr_pkg::CFG_ANGLE, 16'sd6434);
        push_point(ONE, '0, '0);
        push_point('0, ONE, ONE);
        push_point(PMAX, PMIN, PMAX);
        wait_drained();

        // angle extremes fold across +-pi/2
        write_all(16'sd9459, 16'sd9459, 16'sd9459, 16'h7FFF);
        push_point(ONE, ONE, '0);
        push_point(PMIN, PMAX, '1);
        wait_drained();
        write_reg(qpr_pkg::CFG_ANGLE, 16'h8000);
        push_point(ONE, '0, ONE);
        push_point(PMAX, PMAX, PMIN);
        wait_drained();

        // non-unit axis at the register extremes: scaled result clips
        write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'sd3000);
        push_point(ONE, ONE, ONE);
        push_point(PMAX, '0, PMIN);
        push_point(24'h000100, 24'hFFFF00, '0);
        wait_drained();

        // zero angle written explicitly: cordic value, not the exact one
        write_all(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        push_point(PMAX, PMAX, PMAX);
        push_point(ONE, '1, PMIN);
        wait_drained();

        // random settings, each followed by a run of random points
        for (int ph = 0; ph < 12; ph++) begin
            burst_mode = (ph % 4 == 3);
            if (ph % 3 == 0) begin
                write_reg(2'($urandom_range(0, 3)), 16'($urandom));
            end else if (ph % 3 == 1) begin
                ax = 16'($signed(15'($urandom)));
                ay = 16'($signed(15'($urandom)));
                az = 16'($signed(15'($urandom)));
                write_all(ax, ay, az, 16'($urandom));
            end else begin
                write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            push_random_points(60);
            // sender holds off until everything is back
            wait_drained();
        end
        burst_mode = 0;

        wait_drained();
        if (mismatch_count == 0 && expected_rotations.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
sv/qpr_pkg.sv
sv/qpr_quat_gen.sv
sv/qpr_rot_pipe.sv
sv/quaternion_point_rotator.sv
tb/quaternion_point_rotator_tb.sv
